// File: hw/rtl/sncc_pkg.sv
// ----------------------------------------------------------------------------
// sncc_pkg: shared types and constants of the stereo NCC disparity unit
// Widths of the window sums and the score arithmetic, register indexes,
// reset values and quality codes.
// ----------------------------------------------------------------------------
package sncc_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_HALF  = 7;
  localparam int MAX_ROWS      = 1024;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GOOD_THRESHOLD = 2'd3;

  localparam logic [11:0] RST_IMAGE_WIDTH    = 12'd640;
  localparam logic [10:0] RST_IMAGE_HEIGHT   = 11'd480;
  localparam logic [2:0]  RST_HALF_WINDOW    = 3'd2;
  localparam logic [15:0] RST_GOOD_THRESHOLD = 16'd16384;

  // field widths
  localparam int PX_W   = 8;
  localparam int ROW_W  = 10;
  localparam int COL_W  = 11;
  localparam int QUAL_W = 2;
  localparam int HW_W   = 3;   // half window register
  localparam int IDX_W  = 4;   // 0 .. 2h within a window

  // window sums; the radius register limits the side to 15
  localparam int N_W  = 8;     // n = side^2 <= 225
  localparam int S_W  = 16;    // sum of pixels
  localparam int Q_W  = 24;    // sum of products
  localparam int V_W  = 32;    // centered second moments
  localparam int CV_W = 34;    // signed cross moment
  localparam int P_W  = 64;    // product of the two variances
  localparam int L_W  = 95;    // search compare width
  localparam int SC_W = 17;    // signed Q1.15 score

  localparam logic [QUAL_W-1:0] QUAL_GOOD = 2'd0;
  localparam logic [QUAL_W-1:0] QUAL_WEAK = 2'd1;
  localparam logic [QUAL_W-1:0] QUAL_NONE = 2'd2;

  typedef struct packed {
    logic [N_W-1:0] n;
    logic [S_W-1:0] sa;
    logic [S_W-1:0] sb;
    logic [Q_W-1:0] saa;
    logic [Q_W-1:0] sbb;
    logic [Q_W-1:0] sab;
  } win_sums_t;

endpackage

// File: hw/rtl/sncc_line_store.sv
// ----------------------------------------------------------------------------
// sncc_line_store: circular line store of one image
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module sncc_line_store #(
  parameter int DEPTH = 15 * 2048,
  parameter int AW    = 15
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [sncc_pkg::PX_W-1:0]  wdata,
  input  logic [AW-1:0]              raddr,
  output logic [sncc_pkg::PX_W-1:0]  rdata
);

  logic [sncc_pkg::PX_W-1:0] mem [DEPTH];
  logic [sncc_pkg::PX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/sncc_score.sv
// ----------------------------------------------------------------------------
// sncc_score: exact Q1.15 NCC score of one window pair
// Sequencer around one shared 32x32 multiplier; a binary search finds
// the largest m with m*m*va*vb <= cv*cv*2^30.
// ----------------------------------------------------------------------------
module sncc_score (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  sncc_pkg::win_sums_t               sums,
  output logic                              done,
  output logic signed [sncc_pkg::SC_W-1:0]  score
);

  localparam logic [4:0] SC_IDLE = 5'd0;
  localparam logic [4:0] SC_VA0  = 5'd1;
  localparam logic [4:0] SC_VA1  = 5'd2;
  localparam logic [4:0] SC_VB0  = 5'd3;
  localparam logic [4:0] SC_VB1  = 5'd4;
  localparam logic [4:0] SC_CV0  = 5'd5;
  localparam logic [4:0] SC_CV1  = 5'd6;
  localparam logic [4:0] SC_CHK  = 5'd7;
  localparam logic [4:0] SC_P    = 5'd8;
  localparam logic [4:0] SC_MM   = 5'd9;
  localparam logic [4:0] SC_MID  = 5'd10;
  localparam logic [4:0] SC_MSQ  = 5'd11;
  localparam logic [4:0] SC_PLO  = 5'd12;
  localparam logic [4:0] SC_PHI  = 5'd13;
  localparam logic [4:0] SC_SUM  = 5'd14;
  localparam logic [4:0] SC_CMP  = 5'd15;
  localparam logic [4:0] SC_DONE = 5'd16;

  localparam int V_W  = sncc_pkg::V_W;
  localparam int P_W  = sncc_pkg::P_W;
  localparam int L_W  = sncc_pkg::L_W;
  localparam int CV_W = sncc_pkg::CV_W;
  localparam int SC_W = sncc_pkg::SC_W;

  logic [4:0]              st_r, st_nxt;
  sncc_pkg::win_sums_t     sums_r;
  logic [P_W-1:0]          prod_r;
  logic [V_W-1:0]          t_r, va_r, vb_r;
  logic signed [CV_W-1:0]  cv_r;
  logic [P_W-1:0]          p_r;
  logic [L_W-1:0]          rhs_r, lhs_r;
  logic [15:0]             lo_r, hi_r, m_r;
  logic [30:0]             msq_r;
  logic [62:0]             plo_r;
  logic signed [SC_W-1:0]  score_r;

  logic [V_W-1:0]          mul_a, mul_b;
  logic signed [CV_W-1:0]  cv_abs;
  logic [16:0]             mid_sum;

  assign cv_abs  = cv_r[CV_W-1] ? -cv_r : cv_r;
  assign mid_sum = 17'(lo_r) + 17'(hi_r) + 17'd1;

  // operand select of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      SC_VA0: begin mul_a = V_W'(sums_r.n);  mul_b = V_W'(sums_r.saa); end
      SC_VA1: begin mul_a = V_W'(sums_r.sa); mul_b = V_W'(sums_r.sa);  end
      SC_VB0: begin mul_a = V_W'(sums_r.n);  mul_b = V_W'(sums_r.sbb); end
      SC_VB1: begin mul_a = V_W'(sums_r.sb); mul_b = V_W'(sums_r.sb);  end
      SC_CV0: begin mul_a = V_W'(sums_r.n);  mul_b = V_W'(sums_r.sab); end
      SC_CV1: begin mul_a = V_W'(sums_r.sa); mul_b = V_W'(sums_r.sb);  end
      SC_CHK: begin mul_a = va_r;            mul_b = vb_r;             end
      SC_P:   begin mul_a = cv_abs[V_W-1:0]; mul_b = cv_abs[V_W-1:0];  end
      SC_MSQ: begin mul_a = V_W'(m_r);       mul_b = V_W'(m_r);        end
      SC_PLO: begin mul_a = prod_r[V_W-1:0]; mul_b = p_r[V_W-1:0];     end
      SC_PHI: begin mul_a = V_W'(msq_r);     mul_b = p_r[P_W-1:V_W];   end
      default: begin mul_a = '0;             mul_b = '0;               end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      SC_IDLE: if (start) st_nxt = SC_VA0;
      SC_VA0:  st_nxt = SC_VA1;
      SC_VA1:  st_nxt = SC_VB0;
      SC_VB0:  st_nxt = SC_VB1;
      SC_VB1:  st_nxt = SC_CV0;
      SC_CV0:  st_nxt = SC_CV1;
      SC_CV1:  st_nxt = SC_CHK;
      SC_CHK:  st_nxt = (va_r == '0 || vb_r == '0) ? SC_DONE : SC_P;
      SC_P:    st_nxt = SC_MM;
      SC_MM:   st_nxt = SC_MID;
      SC_MID:  st_nxt = (lo_r >= hi_r) ? SC_DONE : SC_MSQ;
      SC_MSQ:  st_nxt = SC_PLO;
      SC_PLO:  st_nxt = SC_PHI;
      SC_PHI:  st_nxt = SC_SUM;
      SC_SUM:  st_nxt = SC_CMP;
      SC_CMP:  st_nxt = SC_MID;
      SC_DONE: st_nxt = SC_IDLE;
      default: st_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SC_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (st_r)
      SC_IDLE: if (start) sums_r <= sums;
      SC_VA1:  t_r  <= prod_r[V_W-1:0];
      SC_VB0:  va_r <= t_r - prod_r[V_W-1:0];
      SC_VB1:  t_r  <= prod_r[V_W-1:0];
      SC_CV0:  vb_r <= t_r - prod_r[V_W-1:0];
      SC_CV1:  t_r  <= prod_r[V_W-1:0];
      SC_CHK: begin
        cv_r <= $signed(CV_W'(t_r)) - $signed(CV_W'(prod_r[V_W-1:0]));
        // flat window scores zero
        if (va_r == '0 || vb_r == '0) score_r <= '0;
      end
      SC_P:    p_r <= prod_r;
      SC_MM: begin
        rhs_r <= L_W'(prod_r) << 30;
        lo_r  <= 16'd0;
        hi_r  <= 16'd32768;
      end
      SC_MID: begin
        m_r <= mid_sum[16:1];
        if (lo_r >= hi_r) begin
          score_r <= cv_r[CV_W-1] ? -$signed(SC_W'(lo_r)) : $signed(SC_W'(lo_r));
        end
      end
      SC_PLO:  msq_r <= prod_r[30:0];
      SC_PHI:  plo_r <= prod_r[62:0];
      SC_SUM:  lhs_r <= L_W'(plo_r) + (L_W'(prod_r) << 32);
      SC_CMP: begin
        if (lhs_r <= rhs_r) begin
          lo_r <= m_r;
        end else begin
          hi_r <= m_r - 16'd1;
        end
      end
      default: ;
    endcase
  end

  assign done  = (st_r == SC_DONE);
  assign score = score_r;

endmodule

// File: hw/rtl/stereo_ncc_disparity_unit.sv
// ----------------------------------------------------------------------------
// stereo_ncc_disparity_unit: NCC block-matching disparity
// Line stores for both images, window walker and result register.
// ----------------------------------------------------------------------------
// A word carries one left and one right pixel at the same raster position.
// Both go into circular line stores of 2*MAX_HALF+1 rows. When a word
// completes the window of an interior pixel (row i, column j), the unit
// scores the left window against every right window of the same row whose
// center column rc runs from h to j, keeps the first best one and emits
// row, column, a quality code and, for a good match, disparity j-rc (zero
// otherwise). For a word that completes a window the unit is busy: each
// candidate walks its (2h+1)^2 pixels one per cycle through the single read
// port of each line store, then the score sequencer runs its square-root
// search of up to sixteen steps on one shared multiplier. The unit takes no
// word while busy; a finished result waits in the output register while the
// next word is accepted.
// There is no clearing pass: rows are always written before they are read.
// ----------------------------------------------------------------------------
module stereo_ncc_disparity_unit #(
  parameter int MAX_WIDTH = sncc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF  = sncc_pkg::DEF_MAX_HALF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sncc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sncc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sncc_pkg::PX_W-1:0]          in_left_pixel,
  input  logic [sncc_pkg::PX_W-1:0]          in_right_pixel,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sncc_pkg::ROW_W-1:0]         out_row,
  output logic [sncc_pkg::COL_W-1:0]         out_col,
  output logic [sncc_pkg::COL_W-1:0]         out_disparity,
  output logic [sncc_pkg::QUAL_W-1:0]        out_quality
);

  localparam int ROWS   = 2 * MAX_HALF + 1;
  localparam int SLOT_W = $clog2(ROWS);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int EW_W   = $clog2(MAX_WIDTH + 1);
  localparam int AW     = SLOT_W + CW;
  localparam int DEPTH  = ROWS << CW;
  localparam int ROW_W  = sncc_pkg::ROW_W;
  localparam int IDX_W  = sncc_pkg::IDX_W;
  localparam int S_W    = sncc_pkg::S_W;
  localparam int Q_W    = sncc_pkg::Q_W;
  localparam int SC_W   = sncc_pkg::SC_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_KICK  = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // configuration registers
  logic [11:0] width_r;
  logic [10:0] height_r;
  logic [2:0]  half_r;
  logic [15:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sncc_pkg::RST_IMAGE_WIDTH;
      height_r <= sncc_pkg::RST_IMAGE_HEIGHT;
      half_r   <= sncc_pkg::RST_HALF_WINDOW;
      thr_r    <= sncc_pkg::RST_GOOD_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sncc_pkg::CFG_IMAGE_WIDTH:    width_r  <= cfg_data[11:0];
        sncc_pkg::CFG_IMAGE_HEIGHT:   height_r <= cfg_data[10:0];
        sncc_pkg::CFG_HALF_WINDOW:    half_r   <= cfg_data[2:0];
        sncc_pkg::CFG_GOOD_THRESHOLD: thr_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // clamped configuration
  logic [EW_W-1:0]           ew;
  logic [10:0]               eh;
  logic [sncc_pkg::HW_W-1:0] h;
  logic [IDX_W-1:0]          twoh;

  always_comb begin
    if (width_r == '0) begin
      ew = EW_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      ew = EW_W'(MAX_WIDTH);
    end else begin
      ew = EW_W'(width_r);
    end
    if (height_r == '0) begin
      eh = 11'd1;
    end else if (32'(height_r) > 32'(sncc_pkg::MAX_ROWS)) begin
      eh = 11'(sncc_pkg::MAX_ROWS);
    end else begin
      eh = height_r;
    end
    if (half_r == '0) begin
      h = 3'd1;
    end else if (32'(half_r) > 32'(MAX_HALF)) begin
      h = 3'(MAX_HALF);
    end else begin
      h = half_r;
    end
  end

  assign twoh = {h, 1'b0};

  // raster position, with the line store slot of the current row
  logic [CW-1:0]     col_r;
  logic [ROW_W-1:0]  row_r;
  logic [SLOT_W-1:0] slot_r;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(ROWS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  logic [2:0] st_r, st_nxt;
  logic       in_fire;

  assign in_ready = (st_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // position of this word after the wrap for a shrunk frame
  logic [CW-1:0]     c_cur;
  logic [10:0]       r_pre;
  logic [ROW_W-1:0]  r_cur;
  logic [SLOT_W-1:0] s_pre, s_cur;
  logic [EW_W-1:0]   c_inc;
  logic [10:0]       r_inc;
  logic              need_res;

  always_comb begin
    c_cur = col_r;
    r_pre = 11'(row_r);
    s_pre = slot_r;
    if (EW_W'(col_r) >= ew) begin
      c_cur = '0;
      r_pre = 11'(row_r) + 11'd1;
      s_pre = slot_inc(slot_r);
    end
    if (r_pre >= eh) begin
      r_cur = '0;
      s_cur = '0;
    end else begin
      r_cur = r_pre[ROW_W-1:0];
      s_cur = s_pre;
    end
    c_inc    = EW_W'(c_cur) + EW_W'(1);
    r_inc    = 11'(r_cur) + 11'd1;
    need_res = (r_cur >= ROW_W'(twoh)) && (c_cur >= CW'(twoh));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (in_fire) begin
      if (c_inc >= ew) begin
        col_r <= '0;
        if (r_inc >= eh) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= r_inc[ROW_W-1:0];
          slot_r <= slot_inc(s_cur);
        end
      end else begin
        col_r  <= c_inc[CW-1:0];
        row_r  <= r_cur;
        slot_r <= s_cur;
      end
    end
  end

  // line stores
  logic [AW-1:0]             waddr, l_raddr, r_raddr;
  logic [sncc_pkg::PX_W-1:0] l_rdata, r_rdata;

  assign waddr = {s_cur, c_cur};

  sncc_line_store #(.DEPTH(DEPTH), .AW(AW)) u_left (
    .clk   (clk),
    .we    (in_fire),
    .waddr (waddr),
    .wdata (in_left_pixel),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  sncc_line_store #(.DEPTH(DEPTH), .AW(AW)) u_right (
    .clk   (clk),
    .we    (in_fire),
    .waddr (waddr),
    .wdata (in_right_pixel),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // window walk: lbase = j-h, rbase = rc-h
  logic [ROW_W-1:0]          i_r;
  logic [CW-1:0]             j_r, lbase_r, rbase_r, lcol_r, rcol_r, best_rb_r;
  logic [SLOT_W-1:0]         slot0_r, slot_rd_r;
  logic [IDX_W-1:0]          di_r, dj_r;
  logic [sncc_pkg::N_W-1:0]  n_r;
  logic                      rd_vld_r, first_r;
  logic [S_W-1:0]            sa_r, sb_r;
  logic [Q_W-1:0]            saa_r, sbb_r, sab_r;
  logic signed [SC_W-1:0]    best_r;
  logic [SLOT_W-1:0]         slot0_nxt;
  logic [15:0]               aa, bb, ab;
  logic                      last_px;

  assign l_raddr = {slot_rd_r, lcol_r};
  assign r_raddr = {slot_rd_r, rcol_r};
  assign last_px = (di_r == twoh) && (dj_r == twoh);
  assign aa = 16'(l_rdata) * 16'(l_rdata);
  assign bb = 16'(r_rdata) * 16'(r_rdata);
  assign ab = 16'(l_rdata) * 16'(r_rdata);

  // slot of the top window row, 2h rows above the current one
  always_comb begin
    if (s_cur < SLOT_W'(twoh)) begin
      slot0_nxt = SLOT_W'(32'(s_cur) + ROWS - 32'(twoh));
    end else begin
      slot0_nxt = s_cur - SLOT_W'(twoh);
    end
  end

  // score unit
  sncc_pkg::win_sums_t    sums;
  logic                   sc_done;
  logic signed [SC_W-1:0] sc_score;

  assign sums = '{n: n_r, sa: sa_r, sb: sb_r, saa: saa_r, sbb: sbb_r, sab: sab_r};

  sncc_score u_score (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ST_KICK),
    .sums  (sums),
    .done  (sc_done),
    .score (sc_score)
  );

  // output register
  logic                        out_valid_r;
  logic [ROW_W-1:0]            out_row_r;
  logic [sncc_pkg::COL_W-1:0]  out_col_r, out_disp_r;
  logic [sncc_pkg::QUAL_W-1:0] out_qual_r;
  logic                        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_fire && need_res) st_nxt = ST_READ;
      ST_READ:  if (last_px) st_nxt = ST_DRAIN;
      ST_DRAIN: st_nxt = ST_KICK;
      ST_KICK:  st_nxt = ST_WAIT;
      ST_WAIT:  if (sc_done) st_nxt = (rbase_r == lbase_r) ? ST_OUT : ST_READ;
      ST_OUT:   if (out_free) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      rd_vld_r <= (st_r == ST_READ);
    end
  end

  always_ff @(posedge clk) begin
    // accumulate the word read in the previous cycle
    if (rd_vld_r) begin
      sa_r  <= sa_r + S_W'(l_rdata);
      sb_r  <= sb_r + S_W'(r_rdata);
      saa_r <= saa_r + Q_W'(aa);
      sbb_r <= sbb_r + Q_W'(bb);
      sab_r <= sab_r + Q_W'(ab);
    end
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire && need_res) begin
          i_r       <= r_cur - ROW_W'(h);
          j_r       <= c_cur - CW'(h);
          lbase_r   <= c_cur - CW'(twoh);
          lcol_r    <= c_cur - CW'(twoh);
          rbase_r   <= '0;
          rcol_r    <= '0;
          slot0_r   <= slot0_nxt;
          slot_rd_r <= slot0_nxt;
          di_r      <= '0;
          dj_r      <= '0;
          n_r       <= 8'(({1'b0, twoh} + 5'd1) * ({1'b0, twoh} + 5'd1));
          first_r   <= 1'b1;
          sa_r      <= '0;
          sb_r      <= '0;
          saa_r     <= '0;
          sbb_r     <= '0;
          sab_r     <= '0;
        end
      end
      ST_READ: begin
        // advance across the row, then down to the next store row
        if (dj_r == twoh) begin
          dj_r      <= '0;
          di_r      <= di_r + IDX_W'(1);
          slot_rd_r <= slot_inc(slot_rd_r);
          lcol_r    <= lbase_r;
          rcol_r    <= rbase_r;
        end else begin
          dj_r   <= dj_r + IDX_W'(1);
          lcol_r <= lcol_r + CW'(1);
          rcol_r <= rcol_r + CW'(1);
        end
      end
      ST_WAIT: begin
        if (sc_done) begin
          // first candidate always taken; later ones only when strictly better
          if (first_r || sc_score > best_r) begin
            best_r    <= sc_score;
            best_rb_r <= rbase_r;
          end
          first_r   <= 1'b0;
          rbase_r   <= rbase_r + CW'(1);
          rcol_r    <= rbase_r + CW'(1);
          lcol_r    <= lbase_r;
          slot_rd_r <= slot0_r;
          di_r      <= '0;
          dj_r      <= '0;
          sa_r      <= '0;
          sb_r      <= '0;
          saa_r     <= '0;
          sbb_r     <= '0;
          sab_r     <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_OUT && out_free) begin
      out_row_r <= i_r;
      out_col_r <= sncc_pkg::COL_W'(j_r);
      priority if (best_r > $signed({1'b0, thr_r})) begin
        out_qual_r <= sncc_pkg::QUAL_GOOD;
        out_disp_r <= sncc_pkg::COL_W'(lbase_r - best_rb_r);
      end else if (best_r > $signed(SC_W'(0))) begin
        out_qual_r <= sncc_pkg::QUAL_WEAK;
        out_disp_r <= '0;
      end else begin
        out_qual_r <= sncc_pkg::QUAL_NONE;
        out_disp_r <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_disparity = out_disp_r;
  assign out_quality   = out_qual_r;

endmodule
